### rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue package
// Shared types, codes and default sizes for the heap controller and datapath.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int HEAP_SLOTS_DEF = 1024;
  localparam int ID_COUNT_DEF   = 4096;
  localparam int KEY_BITS_DEF   = 32;

  localparam int ID_W    = 12;
  localparam int KEY_W   = 32;
  localparam int OCC_W   = 11;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_CHANGE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_PRESENT = 3'd3,
    STAT_ABSENT  = 3'd4
  } status_t;

  typedef struct packed {
    mode_t            mode;
    logic [ID_W-1:0]  element_id;
    logic [KEY_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    status_t          status_code;
    logic [ID_W-1:0]  popped_id;
    logic [KEY_W-1:0] popped_key;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_CHK, S_POPK,
    S_UP_P, S_UP_K, S_UP_C, S_DN_S, S_DN_K, S_DN_C, S_FIN, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_SET_STATUS, OP_INS_START, OP_CHG_START,
    OP_POP_START, OP_POP_KEY, OP_UP_PAR, OP_UP_KEY, OP_UP_MOVE,
    OP_DN_SLOT, OP_DN_KEY, OP_DN_MOVE, OP_PLACE, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  id_ok;
    logic  present;
    logic  full;
    logic  empty;
    logic  ent_gt1;
    logic  par_gt1;
    logic  up_swap;
    logic  has_child;
    logic  dn_swap;
    logic  clr_last;
    logic  out_busy;
  } dp_flags_t;

endpackage

### rtl/imhq_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue controller
// Sequences the clearing pass, the lookup, the sift loops and the result.
// ----------------------------------------------------------------------------
module imhq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  imhq_pkg::dp_flags_t flags,
  output imhq_pkg::dp_cmd_t   cmd
);
  import imhq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = STAT_OK;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (flags.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_LOOK;
        end
      end
      S_LOOK: state_next = S_CHK;
      S_CHK: begin
        state_next = S_DONE;
        case (flags.mode)
          MODE_INSERT: begin
            if (!flags.id_ok) begin
              cmd.op = OP_SET_STATUS; cmd.code = STAT_ABSENT;
            end else if (flags.present) begin
              cmd.op = OP_SET_STATUS; cmd.code = STAT_PRESENT;
            end else if (flags.full) begin
              cmd.op = OP_SET_STATUS; cmd.code = STAT_FULL;
            end else begin
              cmd.op     = OP_INS_START;
              state_next = flags.empty ? S_FIN : S_UP_P;
            end
          end
          MODE_CHANGE: begin
            if (!flags.id_ok || !flags.present) begin
              cmd.op = OP_SET_STATUS; cmd.code = STAT_ABSENT;
            end else begin
              cmd.op     = OP_CHG_START;
              state_next = flags.ent_gt1 ? S_UP_P : S_DN_S;
            end
          end
          MODE_POP: begin
            if (flags.empty) begin
              cmd.op = OP_SET_STATUS; cmd.code = STAT_EMPTY;
            end else begin
              cmd.op     = OP_POP_START;
              state_next = S_POPK;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POPK: begin
        cmd.op     = OP_POP_KEY;
        state_next = flags.empty ? S_DONE : S_DN_S;
      end
      S_UP_P: begin
        cmd.op     = OP_UP_PAR;
        state_next = S_UP_K;
      end
      S_UP_K: begin
        cmd.op     = OP_UP_KEY;
        state_next = S_UP_C;
      end
      S_UP_C: begin
        if (flags.up_swap) begin
          cmd.op = OP_UP_MOVE;
        end
        if (flags.up_swap && flags.par_gt1) begin
          state_next = S_UP_P;
        end else begin
          state_next = (flags.mode == MODE_CHANGE) ? S_DN_S : S_FIN;
        end
      end
      S_DN_S: begin
        if (flags.has_child) begin
          cmd.op     = OP_DN_SLOT;
          state_next = S_DN_K;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_K: begin
        cmd.op     = OP_DN_KEY;
        state_next = S_DN_C;
      end
      S_DN_C: begin
        if (flags.dn_swap) begin
          cmd.op     = OP_DN_MOVE;
          state_next = S_DN_S;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op     = OP_PLACE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!flags.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

### rtl/imhq_dpath.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue datapath
// Heap memories, the element being sifted, and the result register.
// ----------------------------------------------------------------------------
module imhq_dpath #(
  parameter int HEAP_SLOTS = imhq_pkg::HEAP_SLOTS_DEF,
  parameter int ID_COUNT   = imhq_pkg::ID_COUNT_DEF,
  parameter int KEY_BITS   = imhq_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  imhq_pkg::req_t      req,
  input  imhq_pkg::dp_cmd_t   cmd,
  output imhq_pkg::dp_flags_t flags,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output imhq_pkg::rsp_t      rsp
);
  import imhq_pkg::*;

  localparam int SW = $clog2(HEAP_SLOTS + 1);
  localparam int IW = $clog2(ID_COUNT);

  logic [ID_W-1:0]     stm [HEAP_SLOTS + 1];
  logic [SW-1:0]       its [ID_COUNT];
  logic [KEY_BITS-1:0] keym [ID_COUNT];

  // Operation registers.
  mode_t               mode_q;
  logic [ID_W-1:0]     id_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SW-1:0]       count;
  logic [SW-1:0]       slot;
  logic [ID_W-1:0]     cur_id;
  logic [KEY_BITS-1:0] cur_key;
  logic [ID_W-1:0]     id_a, id_b;
  logic [IW-1:0]       clr;
  status_t             stat;
  logic [ID_W-1:0]     pop_id;
  logic [KEY_BITS-1:0] pop_key;

  // Registered read data.
  logic [ID_W-1:0]     sa_q, sb_q;
  logic [SW-1:0]       its_q;
  logic [KEY_BITS-1:0] ka_q, kb_q;

  logic [SW-1:0]       sa_addr, sb_addr, par;
  logic [SW:0]         lc, lc1;
  logic                has_right, pick_b;
  logic [KEY_BITS-1:0] pick_key;
  logic [SW-1:0]       pick_slot;
  logic [ID_W-1:0]     pick_id;

  logic                stm_we, its_we, key_we;
  logic [SW-1:0]       stm_wa, its_wd;
  logic [ID_W-1:0]     stm_wd;
  logic [IW-1:0]       its_wa, key_wa;

  assign par       = slot >> 1;
  assign lc        = {slot, 1'b0};
  assign lc1       = {slot, 1'b1};
  assign has_right = (lc1 <= {1'b0, count});
  assign pick_b    = has_right && (kb_q < ka_q);
  assign pick_key  = pick_b ? kb_q : ka_q;
  assign pick_slot = pick_b ? lc1[SW-1:0] : lc[SW-1:0];
  assign pick_id   = pick_b ? id_b : id_a;

  // The root is read from acceptance until the pop has taken it, so port A
  // rests on slot 1 unless a sift step points it elsewhere.
  always_comb begin
    sa_addr = SW'(1);
    sb_addr = count;
    case (cmd.op)
      OP_UP_PAR:  sa_addr = par;
      OP_DN_SLOT: begin
        sa_addr = lc[SW-1:0];
        sb_addr = lc1[SW-1:0];
      end
      default: sa_addr = SW'(1);
    endcase
  end

  always_comb begin
    stm_we = 1'b0; stm_wa = slot; stm_wd = cur_id;
    its_we = 1'b0; its_wa = IW'(cur_id); its_wd = slot;
    key_we = 1'b0; key_wa = IW'(id_q);
    case (cmd.op)
      OP_CLEAR: begin
        its_we = 1'b1; its_wa = clr; its_wd = '0;
      end
      OP_INS_START, OP_CHG_START: key_we = 1'b1;
      OP_POP_START: begin
        its_we = 1'b1; its_wa = IW'(sa_q); its_wd = '0;
      end
      OP_UP_MOVE: begin
        stm_we = 1'b1; stm_wd = id_a;
        its_we = 1'b1; its_wa = IW'(id_a);
      end
      OP_DN_MOVE: begin
        stm_we = 1'b1; stm_wd = pick_id;
        its_we = 1'b1; its_wa = IW'(pick_id);
      end
      OP_PLACE: begin
        stm_we = 1'b1;
        its_we = 1'b1;
      end
      default: stm_we = 1'b0;
    endcase
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (stm_we) stm[stm_wa] <= stm_wd;
    if (its_we) its[its_wa] <= its_wd;
    if (key_we) keym[key_wa] <= key_q;
    sa_q  <= stm[sa_addr];
    sb_q  <= stm[sb_addr];
    its_q <= its[IW'(id_q)];
    ka_q  <= keym[IW'(sa_q)];
    kb_q  <= keym[IW'(sb_q)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR:     clr <= clr + IW'(1);
        OP_INS_START: count <= count + SW'(1);
        OP_POP_START: count <= count - SW'(1);
        default:      clr <= clr;
      endcase
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        mode_q  <= req.mode;
        id_q    <= req.element_id;
        key_q   <= KEY_BITS'(req.key_value);
        stat    <= STAT_OK;
        pop_id  <= '0;
        pop_key <= '0;
      end
      OP_SET_STATUS: stat <= cmd.code;
      OP_INS_START: begin
        cur_id  <= id_q;
        cur_key <= key_q;
        slot    <= count + SW'(1);
      end
      OP_CHG_START: begin
        cur_id  <= id_q;
        cur_key <= key_q;
        slot    <= its_q;
      end
      OP_POP_START: begin
        id_a <= sa_q;
        id_b <= sb_q;
      end
      OP_POP_KEY: begin
        pop_id  <= id_a;
        pop_key <= ka_q;
        cur_id  <= id_b;
        cur_key <= kb_q;
        slot    <= SW'(1);
      end
      OP_UP_KEY: id_a <= sa_q;
      OP_UP_MOVE: slot <= par;
      OP_DN_KEY: begin
        id_a <= sa_q;
        id_b <= sb_q;
      end
      OP_DN_MOVE: slot <= pick_slot;
      OP_EMIT: begin
        rsp.status_code <= stat;
        rsp.popped_id   <= pop_id;
        rsp.popped_key  <= KEY_W'(pop_key);
        rsp.occupancy   <= OCC_W'(count);
      end
      default: slot <= slot;
    endcase
  end

  always_comb begin
    flags.mode      = mode_q;
    flags.id_ok     = (32'(id_q) < ID_COUNT);
    flags.present   = (its_q != '0);
    flags.full      = (32'(count) >= HEAP_SLOTS);
    flags.empty     = (count == '0);
    flags.ent_gt1   = (its_q > SW'(1));
    flags.par_gt1   = (par > SW'(1));
    flags.up_swap   = (cur_key < ka_q);
    flags.has_child = (lc <= {1'b0, count});
    flags.dn_swap   = (cur_key > pick_key);
    flags.clr_last  = (32'(clr) == ID_COUNT - 1);
    flags.out_busy  = rsp_valid && !rsp_ready;
  end

endmodule

### rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue
// Binary min-heap of element ids with insert, change key and pop minimum.
// ----------------------------------------------------------------------------
// Each request transaction carries one operation and produces exactly one
// response transaction with a status, the popped id and key (zero unless a
// pop succeeds) and the occupancy after the operation. Operations run one at
// a time: a lookup comes first, and each heap level visited by a sift is
// a slot read, a key read, then compare and move. Change key may sift both
// up and down. The response waits in an output register, so a slow consumer
// only holds the block once a second result is ready. After reset the
// id-to-slot map is cleared, one entry per cycle, until all ID_COUNT entries
// are zero; no request is taken during that pass. Keys are compared as
// unsigned values of KEY_BITS.
module indexed_min_heap_queue #(
  parameter int HEAP_SLOTS = imhq_pkg::HEAP_SLOTS_DEF,
  parameter int ID_COUNT   = imhq_pkg::ID_COUNT_DEF,
  parameter int KEY_BITS   = imhq_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  imhq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output imhq_pkg::rsp_t rsp
);
  import imhq_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t   cmd;
  dp_flags_t flags;

  imhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  imhq_dpath #(
    .HEAP_SLOTS (HEAP_SLOTS),
    .ID_COUNT   (ID_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .flags     (flags),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
